[hw/rtl/rbsc_pkg.sv]
// Shared types, constants and helper functions for the rgb brightness,
// saturation and contrast core. No dependencies.
package rbsc_pkg;

  // channel and fixed-point widths
  localparam int ChW     = 8;
  localparam int FracW   = 16;
  localparam int BriW    = 9;
  localparam int SatW    = 10;
  localparam int ConW    = 9;
  localparam int CfgW    = 10;
  localparam int CfgIdxW = 2;

  // saturation stage: s = c*2^16/v, quotient of FracW bits
  localparam int DivaSteps = FracW;
  // saturation stage: t = cq*(v-med)/c, quotient below 2^24
  localparam int DivbSteps = 24;
  localparam int CqW       = 24;
  localparam int ProdW     = CqW + ChW;
  localparam int SW        = FracW + 1;

  // contrast factor: 34-bit dividend, 18-bit divisor
  localparam int FactNumW  = 34;
  localparam int FactDenW  = 18;
  localparam int FactSteps = FactNumW;
  localparam int FactCntW  = 6;
  localparam int FactW     = 25;

  // front to back queue
  localparam int FifoDepth = 4;
  localparam int FifoAw    = 2;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgBright = 2'd0,
    CfgSat    = 2'd1,
    CfgCon    = 2'd2
  } cfg_idx_e;

  // contrast factor divider states
  typedef enum logic {
    FIdle,
    FRun
  } fact_state_e;

  // classified pixel handed from front to back
  typedef struct packed {
    logic [2:0][ChW-1:0] ch;
    logic                do_sat;
    logic                do_con;
    logic                frame_end;
  } item_t;

  // pixel plus its hsv measures inside the back pipeline
  typedef struct packed {
    item_t          it;
    logic [ChW-1:0] v;
    logic [ChW-1:0] mn;
    logic [ChW-1:0] med;
    logic [ChW-1:0] c;
  } ctx_t;

  // one restoring division step result
  typedef struct packed {
    logic [ChW-1:0] rem;
    logic           q;
  } div_step_t;

  // one restoring step with an 8-bit divisor
  function automatic div_step_t div_step(input logic [ChW-1:0] rem,
                                         input logic bit_in,
                                         input logic [ChW-1:0] d);
    logic [ChW:0] sh;
    logic [ChW:0] diff;
    div_step_t    res;
    sh   = {rem, bit_in};
    diff = sh - {1'b0, d};
    if (sh >= {1'b0, d}) begin
      res.rem = diff[ChW-1:0];
      res.q   = 1'b1;
    end else begin
      res.rem = sh[ChW-1:0];
      res.q   = 1'b0;
    end
    return res;
  endfunction

endpackage

[hw/rtl/rbsc_fifo.sv]
// Short queue between the front and back parts of the core.
// Depends on rbsc_pkg for the item type and depth.
module rbsc_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  rbsc_pkg::item_t     wdata_i,
  input  logic                pop_i,
  output rbsc_pkg::item_t     rdata_o,
  output logic                full_o,
  output logic                empty_o
);

  rbsc_pkg::item_t             mem_q [rbsc_pkg::FifoDepth];
  logic [rbsc_pkg::FifoAw-1:0] wptr_q, wptr_d;
  logic [rbsc_pkg::FifoAw-1:0] rptr_q, rptr_d;
  logic [rbsc_pkg::FifoAw:0]   cnt_q, cnt_d;

  // pointer and fill count update
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  assign rdata_o = mem_q[rptr_q];
  assign full_o  = (cnt_q == (rbsc_pkg::FifoAw+1)'(rbsc_pkg::FifoDepth));
  assign empty_o = (cnt_q == '0);

endmodule

[hw/rtl/rbsc_front.sv]
// Front part: takes pixel transfers, applies brightness and classifies
// the pixel for the back part. Depends on rbsc_pkg.
module rbsc_front (
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [rbsc_pkg::ChW-1:0]    red_in_i,
  input  logic [rbsc_pkg::ChW-1:0]    green_in_i,
  input  logic [rbsc_pkg::ChW-1:0]    blue_in_i,
  input  logic                        frame_end_in_i,
  input  logic signed [rbsc_pkg::BriW-1:0] bri_i,
  input  logic signed [rbsc_pkg::SatW-1:0] sat_i,
  input  logic signed [rbsc_pkg::ConW-1:0] con_i,
  input  logic                        fifo_full_i,
  input  logic                        busy_i,
  output logic                        push_o,
  output rbsc_pkg::item_t             item_o
);

  logic [2:0][rbsc_pkg::ChW-1:0] raw;
  logic signed [rbsc_pkg::ChW+2:0] sum [3];
  logic [2:0][rbsc_pkg::ChW-1:0] clamped;
  logic white, gray;

  assign raw = {blue_in_i, green_in_i, red_in_i};

  // brightness add and clamp to 0..255
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum[k] = $signed({3'b000, raw[k]}) + (rbsc_pkg::ChW+3)'(bri_i);
      if (sum[k] < 0) begin
        clamped[k] = '0;
      end else if (sum[k] > 255) begin
        clamped[k] = '1;
      end else begin
        clamped[k] = sum[k][rbsc_pkg::ChW-1:0];
      end
    end
  end

  // classification
  assign white = (clamped[0] == '1) && (clamped[1] == '1) && (clamped[2] == '1);
  assign gray  = (clamped[0] == clamped[1]) && (clamped[1] == clamped[2]);

  always_comb begin
    item_o.ch        = clamped;
    item_o.do_sat    = !white && !gray && (sat_i != '0);
    item_o.do_con    = !white && (con_i != '0);
    item_o.frame_end = frame_end_in_i;
  end

  assign in_ready_o = !fifo_full_i && !busy_i;
  assign push_o     = in_valid_i && in_ready_o;

endmodule

[hw/rtl/rbsc_factor.sv]
// Serial divider for the contrast factor 259(c+255)*2^16/(255(259-c)),
// one quotient bit per cycle after a contrast write. Depends on rbsc_pkg.
module rbsc_factor (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [rbsc_pkg::ConW-1:0]     con_i,
  output logic                                 busy_o,
  output logic signed [rbsc_pkg::FactW-1:0]    factor_o
);

  rbsc_pkg::fact_state_e state_q, state_d;
  logic [rbsc_pkg::FactCntW-1:0] cnt_q, cnt_d;
  logic [rbsc_pkg::FactNumW-1:0] num_q, num_d;
  logic [rbsc_pkg::FactDenW-1:0] rem_q, rem_d;
  logic [rbsc_pkg::FactDenW-1:0] den_q;
  logic                          neg_q;
  logic signed [rbsc_pkg::FactW-1:0] factor_q;

  logic signed [9:0]  cp;
  logic               neg;
  logic [9:0]         mag;
  logic [17:0]        num_base;
  logic signed [10:0] dm_s;
  logic [17:0]        den_new;
  logic [rbsc_pkg::FactDenW:0] sh;
  logic               qbit;
  logic               last;

  // operands of a new division
  always_comb begin
    cp       = 10'(con_i) + 10'sd255;
    neg      = cp[9];
    mag      = neg ? 10'(-cp) : cp;
    num_base = 18'(mag * 18'd259);
    dm_s     = 11'sd259 - 11'(con_i);
    den_new  = 18'(dm_s[9:0] * 18'd255);
  end

  // one restoring step
  always_comb begin
    sh    = {rem_q, num_q[rbsc_pkg::FactNumW-1]};
    qbit  = (sh >= {1'b0, den_q});
    rem_d = qbit ? rbsc_pkg::FactDenW'(sh - {1'b0, den_q})
                 : sh[rbsc_pkg::FactDenW-1:0];
    num_d = {num_q[rbsc_pkg::FactNumW-2:0], qbit};
    last  = (cnt_q == rbsc_pkg::FactCntW'(rbsc_pkg::FactSteps - 1));
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rbsc_pkg::FIdle: begin
        if (start_i) state_d = rbsc_pkg::FRun;
      end
      rbsc_pkg::FRun: begin
        if (start_i) begin
          state_d = rbsc_pkg::FRun;
        end else if (last) begin
          state_d = rbsc_pkg::FIdle;
        end
      end
      default: state_d = rbsc_pkg::FIdle;
    endcase
  end

  // outputs
  always_comb begin
    busy_o = 1'b0;
    case (state_q)
      rbsc_pkg::FIdle: busy_o = 1'b0;
      rbsc_pkg::FRun:  busy_o = 1'b1;
      default:         busy_o = 1'b0;
    endcase
  end

  // step counter
  always_comb begin
    cnt_d = cnt_q;
    if (start_i) begin
      cnt_d = '0;
    end else if (state_q == rbsc_pkg::FRun) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= rbsc_pkg::FIdle;
      cnt_q    <= '0;
      factor_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (state_q == rbsc_pkg::FRun && last && !start_i) begin
        factor_q <= neg_q ? -$signed(num_d[rbsc_pkg::FactW-1:0])
                          : $signed(num_d[rbsc_pkg::FactW-1:0]);
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= {num_base, rbsc_pkg::FracW'(0)};
      rem_q <= '0;
      den_q <= den_new;
      neg_q <= neg;
    end else if (state_q == rbsc_pkg::FRun) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
  end

  assign factor_o = factor_q;

endmodule

[hw/rtl/rbsc_back.sv]
// Back part: hsv saturation round trip through two pipelined dividers,
// then contrast scaling and the output register. Depends on rbsc_pkg.
module rbsc_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              fifo_empty_i,
  input  rbsc_pkg::item_t                   item_i,
  output logic                              pop_o,
  input  logic signed [rbsc_pkg::SatW-1:0]  sat_i,
  input  logic signed [rbsc_pkg::FactW-1:0] factor_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [rbsc_pkg::ChW-1:0]          red_out_o,
  output logic [rbsc_pkg::ChW-1:0]          green_out_o,
  output logic [rbsc_pkg::ChW-1:0]          blue_out_o,
  output logic                              frame_end_out_o
);

  localparam int NA = rbsc_pkg::DivaSteps;
  localparam int NB = rbsc_pkg::DivbSteps;

  logic en;

  // divider a: index 0 is the entry stage
  rbsc_pkg::ctx_t              a_ctx [NA+1];
  logic [rbsc_pkg::ChW-1:0]    a_rem [NA+1];
  logic [rbsc_pkg::FracW-1:0]  a_quo [NA+1];
  logic                        a_vld [NA+1];
  rbsc_pkg::div_step_t         a_st  [NA];

  // saturation clamp, cq and product stages
  rbsc_pkg::ctx_t              p_ctx, m_ctx;
  logic [rbsc_pkg::SW-1:0]     p_s;
  logic [rbsc_pkg::CqW-1:0]    m_cq;
  logic                        p_vld, m_vld;

  // divider b: index 0 holds the product
  rbsc_pkg::ctx_t              b_ctx [NB+1];
  logic [rbsc_pkg::CqW-1:0]    b_cq  [NB+1];
  logic [rbsc_pkg::ChW-1:0]    b_rem [NB+1];
  logic [rbsc_pkg::CqW-1:0]    b_lq  [NB+1];
  logic                        b_vld [NB+1];
  rbsc_pkg::div_step_t         b_st  [NB];

  // reconstruction, contrast product and output stages
  rbsc_pkg::item_t                     r_it;
  logic                                r_vld;
  rbsc_pkg::item_t                     c_it;
  logic signed [rbsc_pkg::FactW+9:0]   c_prod [3];
  logic                                c_vld;
  logic [2:0][rbsc_pkg::ChW-1:0]       o_ch;
  logic                                o_fe;
  logic                                o_vld;

  // entry stage measures
  logic [rbsc_pkg::ChW-1:0] e_v, e_mn, e_med;
  logic [rbsc_pkg::ChW+1:0] e_sum;
  rbsc_pkg::ctx_t           e_ctx;

  logic signed [rbsc_pkg::SW+1:0] s_adj;
  logic [rbsc_pkg::SW-1:0]        s_clamp;
  logic [rbsc_pkg::ChW-1:0]       m_dv;

  logic [rbsc_pkg::CqW-1:0]       rc_t [3];
  logic [rbsc_pkg::CqW-1:0]       rc_q [3];
  logic [rbsc_pkg::CqW:0]         rc_r [3];
  logic [2:0][rbsc_pkg::ChW-1:0]  rc_ch;

  logic signed [rbsc_pkg::ChW:0]      cd [3];
  logic signed [rbsc_pkg::FactW+10:0] ov [3];
  logic [2:0][rbsc_pkg::ChW-1:0]      oc;

  // whole pipeline moves when the output register is free or drained
  assign en    = !o_vld || out_ready_i;
  assign pop_o = en && !fifo_empty_i;

  // max, min and median of the three channels
  always_comb begin
    e_v  = item_i.ch[0];
    e_mn = item_i.ch[0];
    for (int k = 1; k < 3; k++) begin
      if (item_i.ch[k] > e_v)  e_v  = item_i.ch[k];
      if (item_i.ch[k] < e_mn) e_mn = item_i.ch[k];
    end
    e_sum = {2'b00, item_i.ch[0]} + {2'b00, item_i.ch[1]} + {2'b00, item_i.ch[2]}
            - {2'b00, e_v} - {2'b00, e_mn};
    e_med    = e_sum[rbsc_pkg::ChW-1:0];
    e_ctx.it = item_i;
    e_ctx.v  = e_v;
    e_ctx.mn = e_mn;
    e_ctx.med = e_med;
    e_ctx.c  = e_v - e_mn;
  end

  // divider a steps, low dividend bits are zero
  always_comb begin
    for (int i = 0; i < NA; i++) begin
      a_st[i] = rbsc_pkg::div_step(a_rem[i], 1'b0, a_ctx[i].v);
    end
  end

  // divider b steps
  always_comb begin
    for (int i = 0; i < NB; i++) begin
      b_st[i] = rbsc_pkg::div_step(b_rem[i], b_lq[i][rbsc_pkg::CqW-1], b_ctx[i].c);
    end
  end

  // saturation offset into q16 and clamp to 0..1
  always_comb begin
    s_adj = $signed({3'b000, a_quo[NA]})
            + $signed({sat_i[rbsc_pkg::SatW-1], sat_i, 8'h00});
    if (s_adj < 0) begin
      s_clamp = '0;
    end else if (s_adj > $signed((rbsc_pkg::SW+2)'(1 << rbsc_pkg::FracW))) begin
      s_clamp = rbsc_pkg::SW'(1 << rbsc_pkg::FracW);
    end else begin
      s_clamp = s_adj[rbsc_pkg::SW-1:0];
    end
  end

  assign m_dv = m_ctx.v - m_ctx.med;

  // channel rebuild with round half up
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (b_ctx[NB].it.ch[k] == b_ctx[NB].v) begin
        rc_t[k] = '0;
      end else if (b_ctx[NB].it.ch[k] == b_ctx[NB].mn) begin
        rc_t[k] = b_cq[NB];
      end else begin
        rc_t[k] = b_lq[NB];
      end
      rc_q[k]  = {b_ctx[NB].v, rbsc_pkg::FracW'(0)} - rc_t[k];
      rc_r[k]  = {1'b0, rc_q[k]} + (rbsc_pkg::CqW+1)'(1 << (rbsc_pkg::FracW - 1));
      rc_ch[k] = b_ctx[NB].it.do_sat ? rc_r[k][rbsc_pkg::CqW-1:rbsc_pkg::FracW]
                                     : b_ctx[NB].it.ch[k];
    end
  end

  // contrast operand about 128
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cd[k] = $signed({1'b0, r_it.ch[k]}) - 9'sd128;
    end
  end

  // contrast offset, truncation and clamp
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ov[k] = (rbsc_pkg::FactW+11)'(c_prod[k])
              + (rbsc_pkg::FactW+11)'(128 << rbsc_pkg::FracW);
      if (!c_it.do_con) begin
        oc[k] = c_it.ch[k];
      end else if (ov[k] < 0) begin
        oc[k] = '0;
      end else if (ov[k][rbsc_pkg::FactW+10:rbsc_pkg::FracW+rbsc_pkg::ChW] != '0) begin
        oc[k] = '1;
      end else begin
        oc[k] = ov[k][rbsc_pkg::FracW+rbsc_pkg::ChW-1:rbsc_pkg::FracW];
      end
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= NA; i++) a_vld[i] <= 1'b0;
      for (int i = 0; i <= NB; i++) b_vld[i] <= 1'b0;
      p_vld <= 1'b0;
      m_vld <= 1'b0;
      r_vld <= 1'b0;
      c_vld <= 1'b0;
      o_vld <= 1'b0;
    end else if (en) begin
      a_vld[0] <= !fifo_empty_i;
      for (int i = 0; i < NA; i++) a_vld[i+1] <= a_vld[i];
      p_vld    <= a_vld[NA];
      m_vld    <= p_vld;
      b_vld[0] <= m_vld;
      for (int i = 0; i < NB; i++) b_vld[i+1] <= b_vld[i];
      r_vld <= b_vld[NB];
      c_vld <= r_vld;
      o_vld <= c_vld;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      a_ctx[0] <= e_ctx;
      a_rem[0] <= e_ctx.c;
      a_quo[0] <= '0;
      for (int i = 0; i < NA; i++) begin
        a_ctx[i+1] <= a_ctx[i];
        a_rem[i+1] <= a_st[i].rem;
        a_quo[i+1] <= {a_quo[i][rbsc_pkg::FracW-2:0], a_st[i].q};
      end
      p_ctx <= a_ctx[NA];
      p_s   <= s_clamp;
      m_ctx <= p_ctx;
      m_cq  <= rbsc_pkg::CqW'(p_ctx.v * p_s);
      b_ctx[0] <= m_ctx;
      b_cq[0]  <= m_cq;
      {b_rem[0], b_lq[0]} <= rbsc_pkg::ProdW'(m_cq * m_dv);
      for (int i = 0; i < NB; i++) begin
        b_ctx[i+1] <= b_ctx[i];
        b_cq[i+1]  <= b_cq[i];
        b_rem[i+1] <= b_st[i].rem;
        b_lq[i+1]  <= {b_lq[i][rbsc_pkg::CqW-2:0], b_st[i].q};
      end
      r_it <= {rc_ch, b_ctx[NB].it.do_sat, b_ctx[NB].it.do_con,
               b_ctx[NB].it.frame_end};
      c_it <= r_it;
      for (int k = 0; k < 3; k++) begin
        c_prod[k] <= factor_i * cd[k];
      end
      o_ch <= oc;
      o_fe <= c_it.frame_end;
    end
  end

  assign out_valid_o     = o_vld;
  assign red_out_o       = o_ch[0];
  assign green_out_o     = o_ch[1];
  assign blue_out_o      = o_ch[2];
  assign frame_end_out_o = o_fe;

endmodule

[hw/rtl/rgb_brightness_saturation_contrast_core.sv]
// One pixel per cycle while the output is not stalled and no contrast factor update runs.
// The back pipeline holds two restoring dividers, 16 and 24 steps.
// After a contrast_level write the factor divider runs, and input is not ready until it ends.
// Reset clears the configuration and factor registers to zero, empties the queue and pipeline valid bits.
// Depends on rbsc_pkg, rbsc_front, rbsc_fifo, rbsc_factor, rbsc_back.
module rgb_brightness_saturation_contrast_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rbsc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [rbsc_pkg::CfgW-1:0]       cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [rbsc_pkg::ChW-1:0]        red_in_i,
  input  logic [rbsc_pkg::ChW-1:0]        green_in_i,
  input  logic [rbsc_pkg::ChW-1:0]        blue_in_i,
  input  logic                            frame_end_in_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [rbsc_pkg::ChW-1:0]        red_out_o,
  output logic [rbsc_pkg::ChW-1:0]        green_out_o,
  output logic [rbsc_pkg::ChW-1:0]        blue_out_o,
  output logic                            frame_end_out_o
);

  logic signed [rbsc_pkg::BriW-1:0]  bri_q;
  logic signed [rbsc_pkg::SatW-1:0]  sat_q;
  logic signed [rbsc_pkg::ConW-1:0]  con_q;
  logic                              con_start;
  logic                              busy;
  logic signed [rbsc_pkg::FactW-1:0] factor;
  logic                              push, pop, full, empty;
  rbsc_pkg::item_t                   wdata, rdata;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bri_q <= '0;
      sat_q <= '0;
      con_q <= '0;
    end else if (cfg_we_i) begin
      case (rbsc_pkg::cfg_idx_e'(cfg_idx_i))
        rbsc_pkg::CfgBright: bri_q <= cfg_data_i[rbsc_pkg::BriW-1:0];
        rbsc_pkg::CfgSat:    sat_q <= cfg_data_i[rbsc_pkg::SatW-1:0];
        rbsc_pkg::CfgCon:    con_q <= cfg_data_i[rbsc_pkg::ConW-1:0];
        default: ;
      endcase
    end
  end

  assign con_start = cfg_we_i && (cfg_idx_i == rbsc_pkg::CfgCon);

  rbsc_factor u_factor (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (con_start),
    .con_i    ($signed(cfg_data_i[rbsc_pkg::ConW-1:0])),
    .busy_o   (busy),
    .factor_o (factor)
  );

  rbsc_front u_front (
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .red_in_i       (red_in_i),
    .green_in_i     (green_in_i),
    .blue_in_i      (blue_in_i),
    .frame_end_in_i (frame_end_in_i),
    .bri_i          (bri_q),
    .sat_i          (sat_q),
    .con_i          (con_q),
    .fifo_full_i    (full),
    .busy_i         (busy),
    .push_o         (push),
    .item_o         (wdata)
  );

  rbsc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wdata),
    .pop_i   (pop),
    .rdata_o (rdata),
    .full_o  (full),
    .empty_o (empty)
  );

  rbsc_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .fifo_empty_i    (empty),
    .item_i          (rdata),
    .pop_o           (pop),
    .sat_i           (sat_q),
    .factor_i        (factor),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .red_out_o       (red_out_o),
    .green_out_o     (green_out_o),
    .blue_out_o      (blue_out_o),
    .frame_end_out_o (frame_end_out_o)
  );

endmodule

[hw/rtl/rbsc_checker.sv]
// Port-level checks for the rgb adjust core, bound to the top level.
// Depends on rbsc_pkg for widths and register indexes.
module rbsc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          cfg_we_i,
  input logic [rbsc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input logic [rbsc_pkg::CfgW-1:0]     cfg_data_i,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic [rbsc_pkg::ChW-1:0]      red_in_i,
  input logic [rbsc_pkg::ChW-1:0]      green_in_i,
  input logic [rbsc_pkg::ChW-1:0]      blue_in_i,
  input logic                          frame_end_in_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [rbsc_pkg::ChW-1:0]      red_out_o,
  input logic [rbsc_pkg::ChW-1:0]      green_out_o,
  input logic [rbsc_pkg::ChW-1:0]      blue_out_o,
  input logic                          frame_end_out_o
);

  // a stalled output transfer keeps valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output valid dropped while stalled");

  // a stalled output transfer keeps its pixel
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(red_out_o) && $stable(green_out_o)
      && $stable(blue_out_o) && $stable(frame_end_out_o))
    else $error("output pixel changed while stalled");

  // contrast factor recompute blocks input next cycle
  a_con_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && (cfg_idx_i == rbsc_pkg::CfgCon) |=> !in_ready_o)
    else $error("input ready during contrast factor update");

  // and still blocks it later while the factor is computed
  a_con_busy_later: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && (cfg_idx_i == rbsc_pkg::CfgCon) |-> ##3 !in_ready_o)
    else $error("contrast factor update ended too early");

endmodule

bind rgb_brightness_saturation_contrast_core rbsc_checker u_rbsc_checker (.*);

[tb/tb_rgb_brightness_saturation_contrast_core.sv]
// Self-checking testbench for rgb_brightness_saturation_contrast_core: directed table, then
// random pixels over many register settings, checked against a behavioral pixel predictor.
// Depends on rbsc_pkg and the core RTL.
module tb_rgb_brightness_saturation_contrast_core;
  timeunit 1ns;
  timeprecision 1ps;

  // index past the last register, writes to it are dropped
  localparam logic [rbsc_pkg::CfgIdxW-1:0] CfgUnused = 2'd3;
  localparam int IdlePct    = 13;
  localparam int Settle     = 60;
  localparam int StallLimit = 3000;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       fe;
  } pixel_t;

  typedef struct {
    int     bri;
    int     sat;
    int     con;
    pixel_t px;
    bit     typed;
    pixel_t want;
  } dir_row_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [rbsc_pkg::CfgIdxW-1:0] cfg_idx_i;
  logic [rbsc_pkg::CfgW-1:0]    cfg_data_i;
  logic                         in_valid_i;
  logic                         in_ready_o;
  logic [7:0]                   red_in_i, green_in_i, blue_in_i;
  logic                         frame_end_in_i;
  logic                         out_valid_o;
  logic                         out_ready_i;
  logic [7:0]                   red_out_o, green_out_o, blue_out_o;
  logic                         frame_end_out_o;

  // local copy of the adjustment registers
  logic signed [rbsc_pkg::BriW-1:0] bri_q;
  logic signed [rbsc_pkg::SatW-1:0] sat_q;
  logic signed [rbsc_pkg::ConW-1:0] con_q;

  pixel_t   pending_pixels[$];
  dir_row_t dir_rows[$];
  int       errors;
  bit       quiet;
  int       stall_cnt;

  rgb_brightness_saturation_contrast_core u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .red_in_i, .green_in_i, .blue_in_i, .frame_end_in_i,
    .out_valid_o, .out_ready_i, .red_out_o, .green_out_o, .blue_out_o, .frame_end_out_o
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint clip8(longint v);
    if (v < 0) return 0;
    if (v > 255) return 255;
    return v;
  endfunction

  // brightness, hsv saturation and contrast on one pixel
  function automatic pixel_t adjust_pixel(pixel_t p);
    longint ch[3];
    longint bri, sat, con, v, mn, c, s, cq, t, q, num, den, f, val;
    pixel_t res;
    bri = longint'(bri_q);
    sat = longint'(sat_q);
    con = longint'(con_q);
    ch[0] = clip8(longint'(p.r) + bri);
    ch[1] = clip8(longint'(p.g) + bri);
    ch[2] = clip8(longint'(p.b) + bri);
    if (!(ch[0] == 255 && ch[1] == 255 && ch[2] == 255)) begin
      if (sat != 0 && !(ch[0] == ch[1] && ch[1] == ch[2])) begin
        v  = ch[0];
        mn = ch[0];
        for (int k = 1; k < 3; k++) begin
          if (ch[k] > v) v = ch[k];
          if (ch[k] < mn) mn = ch[k];
        end
        c = v - mn;
        s = (c * 65536) / v + sat * 256;
        if (s < 0) s = 0;
        if (s > 65536) s = 65536;
        cq = v * s;
        for (int k = 0; k < 3; k++) begin
          t = (cq * (v - ch[k])) / c;
          q = v * 65536 - t;
          ch[k] = clip8((q + 32768) / 65536);
        end
      end
      if (con != 0) begin
        num = 259 * (con + 255) * 65536;
        den = 255 * (259 - con);
        f   = num / den;
        for (int k = 0; k < 3; k++) begin
          val = f * (ch[k] - 128) + 128 * 65536;
          ch[k] = (val < 0) ? 0 : clip8(val / 65536);
        end
      end
    end
    res.r  = ch[0][7:0];
    res.g  = ch[1][7:0];
    res.b  = ch[2][7:0];
    res.fe = p.fe;
    return res;
  endfunction

  // receiver stalls, none while quiet
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= quiet || ($urandom_range(99) >= IdlePct);
    end
  end

  // compare each output transfer with the oldest pending pixel
  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected output r=%0d g=%0d b=%0d fe=%0b", $time,
                 red_out_o, green_out_o, blue_out_o, frame_end_out_o);
        errors++;
      end else begin
        want = pending_pixels.pop_front();
        if (red_out_o !== want.r) begin
          $display("%0t: red expected %0d actual %0d", $time, want.r, red_out_o);
          errors++;
        end
        if (green_out_o !== want.g) begin
          $display("%0t: green expected %0d actual %0d", $time, want.g, green_out_o);
          errors++;
        end
        if (blue_out_o !== want.b) begin
          $display("%0t: blue expected %0d actual %0d", $time, want.b, blue_out_o);
          errors++;
        end
        if (frame_end_out_o !== want.fe) begin
          $display("%0t: frame_end expected %0b actual %0b", $time, want.fe,
                   frame_end_out_o);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= StallLimit) begin
      $display("%0t: timeout, %0d pixels outstanding", $time, pending_pixels.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  // offer one pixel and wait for its transfer; push the expected result
  task automatic send_pixel(pixel_t p, bit typed, pixel_t want);
    while (!quiet && $urandom_range(99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    red_in_i       <= p.r;
    green_in_i     <= p.g;
    blue_in_i      <= p.b;
    frame_end_in_i <= p.fe;
    do @(posedge clk_i); while (!in_ready_o);
    pending_pixels.push_back(typed ? want : adjust_pixel(p));
  endtask

  // stop sending and let the pipeline empty
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
  endtask

  task automatic set_regs(int bri, int sat, int con);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= rbsc_pkg::CfgBright;
    cfg_data_i <= rbsc_pkg::CfgW'(bri);
    @(posedge clk_i);
    cfg_idx_i  <= rbsc_pkg::CfgSat;
    cfg_data_i <= rbsc_pkg::CfgW'(sat);
    @(posedge clk_i);
    cfg_idx_i  <= rbsc_pkg::CfgCon;
    cfg_data_i <= rbsc_pkg::CfgW'(con);
    @(posedge clk_i);
    cfg_idx_i  <= CfgUnused;
    cfg_data_i <= rbsc_pkg::CfgW'($urandom);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    bri_q = rbsc_pkg::BriW'(bri);
    sat_q = rbsc_pkg::SatW'(sat);
    con_q = rbsc_pkg::ConW'(con);
  endtask

  task automatic add_row(int bri, int sat, int con, logic [7:0] r, logic [7:0] g,
                         logic [7:0] b, bit fe, bit typed, logic [7:0] wr,
                         logic [7:0] wg, logic [7:0] wb);
    dir_row_t row;
    row.bri   = bri;
    row.sat   = sat;
    row.con   = con;
    row.px    = '{r: r, g: g, b: b, fe: fe};
    row.typed = typed;
    row.want  = '{r: wr, g: wg, b: wb, fe: fe};
    dir_rows.push_back(row);
  endtask

  function automatic pixel_t rand_pixel();
    pixel_t p;
    int kind;
    kind = $urandom_range(9);
    p.r  = 8'($urandom);
    p.g  = 8'($urandom);
    p.b  = 8'($urandom);
    p.fe = ($urandom_range(15) == 0);
    if (kind == 0) begin
      p.g = p.r;
      p.b = p.r;
    end else if (kind == 1) begin
      p.r = 8'($urandom_range(255, 248));
      p.g = 8'($urandom_range(255, 248));
      p.b = 8'($urandom_range(255, 248));
    end else if (kind == 2) begin
      p.r = ($urandom_range(1)) ? 8'hff : 8'h00;
      p.b = ($urandom_range(1)) ? 8'hff : 8'h00;
    end
    return p;
  endfunction

  initial begin
    int bri_set[14] = '{0, 255, -256, 0, 0, 0, 0, 40, -60, 0, 0, -256, 255, 0};
    int sat_set[14] = '{0, 0, 0, 511, -512, 256, -256, 100, -30, 0, 0, 511, -512, 0};
    int con_set[14] = '{0, 0, 0, 0, 0, 0, 0, 0, 90, 255, -256, 255, -256, 0};
    int cur_bri, cur_sat, cur_con;
    pixel_t none;

    errors         = 0;
    quiet          = 1'b0;
    stall_cnt      = 0;
    none           = '0;
    bri_q          = '0;
    sat_q          = '0;
    con_q          = '0;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = rbsc_pkg::CfgBright;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    red_in_i       = '0;
    green_in_i     = '0;
    blue_in_i      = '0;
    frame_end_in_i = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: identity after reset, forced white and black, then each stage
    add_row(0, 0, 0, 8'h00, 8'h00, 8'h00, 0, 1, 8'h00, 8'h00, 8'h00);
    add_row(0, 0, 0, 8'hff, 8'hff, 8'hff, 1, 1, 8'hff, 8'hff, 8'hff);
    add_row(0, 0, 0, 8'hff, 8'h00, 8'h80, 0, 1, 8'hff, 8'h00, 8'h80);
    add_row(0, 0, 0, 8'h01, 8'h02, 8'hfe, 1, 1, 8'h01, 8'h02, 8'hfe);
    add_row(255, 0, 0, 8'h00, 8'h00, 8'h00, 0, 1, 8'hff, 8'hff, 8'hff);
    add_row(255, 0, 0, 8'h0a, 8'hc8, 8'h03, 1, 1, 8'hff, 8'hff, 8'hff);
    add_row(-256, 0, 0, 8'hff, 8'hff, 8'hff, 0, 1, 8'h00, 8'h00, 8'h00);
    add_row(-256, 0, 0, 8'hc8, 8'h64, 8'h05, 1, 1, 8'h00, 8'h00, 8'h00);
    add_row(0, 511, 0, 8'hc8, 8'h64, 8'h32, 0, 0, 0, 0, 0);
    add_row(0, 511, 0, 8'h64, 8'h64, 8'h64, 0, 0, 0, 0, 0);
    add_row(0, 511, 0, 8'h00, 8'h00, 8'h01, 1, 0, 0, 0, 0);
    add_row(0, -512, 0, 8'hff, 8'h00, 8'h00, 0, 0, 0, 0, 0);
    add_row(0, -512, 0, 8'h0c, 8'h22, 8'h38, 0, 0, 0, 0, 0);
    add_row(0, 256, 0, 8'h80, 8'h40, 8'h00, 0, 0, 0, 0, 0);
    add_row(0, 0, 255, 8'h00, 8'h80, 8'hff, 0, 0, 0, 0, 0);
    add_row(0, 0, 255, 8'h7f, 8'h81, 8'hc8, 1, 0, 0, 0, 0);
    add_row(0, 0, -256, 8'h00, 8'hff, 8'h80, 0, 0, 0, 0, 0);
    add_row(0, 0, -256, 8'h4d, 8'h01, 8'hfa, 0, 0, 0, 0, 0);
    add_row(30, -100, 60, 8'hfa, 8'hfa, 8'hfa, 0, 0, 0, 0, 0);
    add_row(30, -100, 60, 8'h28, 8'h5a, 8'hc8, 1, 0, 0, 0, 0);

    cur_bri = 1;
    cur_sat = 1;
    cur_con = 1;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].bri != cur_bri || dir_rows[i].sat != cur_sat ||
          dir_rows[i].con != cur_con) begin
        cur_bri = dir_rows[i].bri;
        cur_sat = dir_rows[i].sat;
        cur_con = dir_rows[i].con;
        set_regs(cur_bri, cur_sat, cur_con);
      end
      send_pixel(dir_rows[i].px, dir_rows[i].typed, dir_rows[i].want);
    end

    // random pixels across fixed and random register settings
    for (int ph = 0; ph < 20; ph++) begin
      if (ph < 14) begin
        set_regs(bri_set[ph], sat_set[ph], con_set[ph]);
      end else begin
        set_regs($urandom_range(511) - 256, $urandom_range(1023) - 512,
                 $urandom_range(511) - 256);
      end
      quiet = (ph == 3);
      for (int n = 0; n < 72; n++) begin
        if (ph == 8 && n == 36) begin
          drain();
        end
        send_pixel(rand_pixel(), 0, none);
      end
    end
    quiet = 1'b0;

    drain();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
